[hdl/kpm_pkg.sv]
// Shared types and constants of the measurement-report parser.
`default_nettype none

package kpm_pkg;

    // Parser position inside the message layout. Field and string phases use
    // the same code as the result kind that they produce.
    typedef enum logic [3:0] {
        PH_PERIOD     = 4'd0,
        PH_INFO_CNT   = 4'd1,
        PH_NAME_LEN   = 4'd2,
        PH_NAME_BYTE  = 4'd3,
        PH_REC_CNT    = 4'd4,
        PH_FORM       = 4'd5,
        PH_INT        = 4'd6,
        PH_REAL       = 4'd7,
        PH_LBL_CNT    = 4'd8,
        PH_QOS        = 4'd9,
        PH_SLICE_LEN  = 4'd10,
        PH_SLICE_BYTE = 4'd11,
        PH_PLMN_LEN   = 4'd12,
        PH_PLMN_BYTE  = 4'd13,
        PH_DONE       = 4'd14
    } t_phase;

    localparam logic [3:0] KIND_OK    = 4'd14;
    localparam logic [3:0] KIND_TRUNC = 4'd15;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic        last;
    } t_result;

    // Up to two results produced by one accepted byte.
    typedef struct packed {
        logic    v0;
        t_result r0;
        logic    v1;
        t_result r1;
    } t_push;

    // Number of bytes in each fixed-size field.
    function automatic logic [3:0] field_len(input t_phase ph);
        logic [3:0] len;
        begin
            case (ph)
                PH_PERIOD:    len = 4'd4;
                PH_INFO_CNT:  len = 4'd4;
                PH_NAME_LEN:  len = 4'd2;
                PH_REC_CNT:   len = 4'd4;
                PH_INT:       len = 4'd8;
                PH_REAL:      len = 4'd8;
                PH_LBL_CNT:   len = 4'd4;
                PH_QOS:       len = 4'd2;
                PH_SLICE_LEN: len = 4'd2;
                PH_PLMN_LEN:  len = 4'd2;
                default:      len = 4'd1;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/kpm_if.sv]
// Valid/ready channel interfaces for input bytes and parser results.
`default_nettype none

interface kpm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface kpm_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

[hdl/kpm_report_tlv_parser_unit.sv]
// Top level of the streaming measurement-report parser.
// Results are registered in the result queue as the byte that completes them is accepted.
// Throughput: one byte per cycle while the queue has room; a final byte may yield
// two results; the four-entry result queue drains one per cycle while the output is ready.
// Input ready depends only on queue fill, so bytes keep flowing while a result waits.
// Reset (synchronous, active low) returns the parser to the period field and empties the queue.
`default_nettype none

module kpm_report_tlv_parser_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kpm_in_if.sink     i_in,
    kpm_out_if.source  o_out
);

    kpm_pkg::t_push push;
    logic           room;
    logic           take;

    assign i_in.ready = room;
    assign take       = i_in.valid && room;

    kpm_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_in.data_byte),
        .i_eom       (i_in.end_of_message),
        .o_push      (push)
    );

    kpm_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[hdl/kpm_parse_core.sv]
// Parser state and per-byte decode that produces up to two results.
`default_nettype none

module kpm_parse_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_eom,
    output kpm_pkg::t_push     o_push
);

    kpm_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_idx, n_idx;
    logic [63:0]     r_asm, n_asm;
    logic [31:0]     r_infos, n_infos;
    logic [31:0]     r_records, n_records;
    logic [31:0]     r_labels, n_labels;
    logic [15:0]     r_string, n_string;

    logic [63:0] full;
    logic [3:0]  idx_next;
    logic        fld_done;
    logic        is_string;
    logic [31:0] infos_dec, records_dec, labels_dec;
    logic [15:0] string_dec;
    logic        fin_label, fin_info;
    logic        ev_valid;
    logic [63:0] ev_value;

    assign infos_dec   = r_infos - 32'd1;
    assign records_dec = r_records - 32'd1;
    assign labels_dec  = r_labels - 32'd1;
    assign string_dec  = r_string - 16'd1;
    assign idx_next    = {1'b0, r_idx} + 4'd1;
    assign fld_done    = idx_next >= kpm_pkg::field_len(r_phase);
    assign is_string   = (r_phase == kpm_pkg::PH_NAME_BYTE) ||
                         (r_phase == kpm_pkg::PH_SLICE_BYTE) ||
                         (r_phase == kpm_pkg::PH_PLMN_BYTE);

    // Lanes at and above the byte index are still zero, so inserting the byte
    // into its lane gives the little-endian field gathered so far.
    always_comb begin
        full = r_asm;
        for (int k = 0; k < 8; k++) begin
            if (r_idx == 3'(k)) begin
                full[8*k +: 8] = i_data_byte;
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_asm     = r_asm;
        n_infos   = r_infos;
        n_records = r_records;
        n_labels  = r_labels;
        n_string  = r_string;
        fin_label = 1'b0;
        fin_info  = 1'b0;
        ev_valid  = 1'b0;
        ev_value  = '0;

        if (r_phase != kpm_pkg::PH_DONE) begin
            if (is_string) begin
                ev_valid = 1'b1;
                ev_value = {56'd0, i_data_byte};
                n_string = string_dec;
                if (string_dec == 16'd0) begin
                    case (r_phase)
                        kpm_pkg::PH_NAME_BYTE:  n_phase = kpm_pkg::PH_REC_CNT;
                        kpm_pkg::PH_SLICE_BYTE: n_phase = kpm_pkg::PH_PLMN_LEN;
                        default:                fin_label = 1'b1;
                    endcase
                end
            end else if (!fld_done) begin
                n_asm = full;
                n_idx = idx_next[2:0];
            end else begin
                n_asm    = '0;
                n_idx    = '0;
                ev_valid = 1'b1;
                ev_value = full;
                case (r_phase)
                    kpm_pkg::PH_PERIOD: n_phase = kpm_pkg::PH_INFO_CNT;
                    kpm_pkg::PH_INFO_CNT: begin
                        n_infos = full[31:0];
                        n_phase = (full[31:0] == 32'd0) ? kpm_pkg::PH_DONE
                                                        : kpm_pkg::PH_NAME_LEN;
                    end
                    kpm_pkg::PH_NAME_LEN: begin
                        n_string = full[15:0];
                        n_phase  = (full[15:0] == 16'd0) ? kpm_pkg::PH_REC_CNT
                                                         : kpm_pkg::PH_NAME_BYTE;
                    end
                    kpm_pkg::PH_REC_CNT: begin
                        n_records = full[31:0];
                        n_phase   = (full[31:0] == 32'd0) ? kpm_pkg::PH_LBL_CNT
                                                          : kpm_pkg::PH_FORM;
                    end
                    kpm_pkg::PH_FORM: n_phase = kpm_pkg::PH_INT;
                    kpm_pkg::PH_INT:  n_phase = kpm_pkg::PH_REAL;
                    kpm_pkg::PH_REAL: begin
                        n_records = records_dec;
                        n_phase   = (records_dec == 32'd0) ? kpm_pkg::PH_LBL_CNT
                                                           : kpm_pkg::PH_FORM;
                    end
                    kpm_pkg::PH_LBL_CNT: begin
                        n_labels = full[31:0];
                        if (full[31:0] == 32'd0) begin
                            fin_info = 1'b1;
                        end else begin
                            n_phase = kpm_pkg::PH_QOS;
                        end
                    end
                    kpm_pkg::PH_QOS: begin
                        // Flag byte becomes a single bit above the value byte.
                        ev_value = {55'd0, |full[7:0], full[15:8]};
                        n_phase  = kpm_pkg::PH_SLICE_LEN;
                    end
                    kpm_pkg::PH_SLICE_LEN: begin
                        n_string = full[15:0];
                        n_phase  = (full[15:0] == 16'd0) ? kpm_pkg::PH_PLMN_LEN
                                                         : kpm_pkg::PH_SLICE_BYTE;
                    end
                    kpm_pkg::PH_PLMN_LEN: begin
                        n_string = full[15:0];
                        if (full[15:0] == 16'd0) begin
                            fin_label = 1'b1;
                        end else begin
                            n_phase = kpm_pkg::PH_PLMN_BYTE;
                        end
                    end
                    default: n_phase = kpm_pkg::PH_DONE;
                endcase
            end
        end

        if (fin_label) begin
            n_labels = labels_dec;
            if (labels_dec == 32'd0) begin
                fin_info = 1'b1;
            end else begin
                n_phase = kpm_pkg::PH_QOS;
            end
        end
        if (fin_info) begin
            n_infos = infos_dec;
            n_phase = (infos_dec == 32'd0) ? kpm_pkg::PH_DONE : kpm_pkg::PH_NAME_LEN;
        end

        o_push.v0       = i_take && ev_valid;
        o_push.r0.kind  = r_phase;
        o_push.r0.value = ev_value;
        o_push.r0.last  = 1'b0;
        o_push.v1       = i_take && i_eom;
        o_push.r1.kind  = (n_phase == kpm_pkg::PH_DONE) ? kpm_pkg::KIND_OK
                                                        : kpm_pkg::KIND_TRUNC;
        o_push.r1.value = '0;
        o_push.r1.last  = 1'b1;

        // The final byte rearms the parser for the next message.
        if (i_eom) begin
            n_phase   = kpm_pkg::PH_PERIOD;
            n_idx     = '0;
            n_asm     = '0;
            n_infos   = '0;
            n_records = '0;
            n_labels  = '0;
            n_string  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= kpm_pkg::PH_PERIOD;
            r_idx     <= '0;
            r_asm     <= '0;
            r_infos   <= '0;
            r_records <= '0;
            r_labels  <= '0;
            r_string  <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_asm     <= n_asm;
            r_infos   <= n_infos;
            r_records <= n_records;
            r_labels  <= n_labels;
            r_string  <= n_string;
        end
    end

endmodule

`default_nettype wire

[hdl/kpm_out_fifo.sv]
// Small result queue that takes up to two results per cycle and gives one when output is ready.
`default_nettype none

module kpm_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kpm_pkg::t_push i_push,
    output logic               o_room,
    kpm_out_if.source          o_out
);

    localparam int PTR_W = $clog2(kpm_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(kpm_pkg::FIFO_DEPTH + 1);

    kpm_pkg::t_result r_mem [kpm_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic             pop;
    logic [1:0]       n_in;
    logic [PTR_W-1:0] wr_ptr_1;
    kpm_pkg::t_result first;

    assign pop      = o_out.valid && o_out.ready;
    assign n_in     = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign wr_ptr_1 = r_wr_ptr + PTR_W'(1);
    assign first    = i_push.v0 ? i_push.r0 : i_push.r1;

    // Room for two results is kept whenever a byte may be taken.
    assign o_room = r_count <= CNT_W'(kpm_pkg::FIFO_DEPTH - 2);

    assign o_out.valid = r_count != '0;
    assign o_out.kind  = r_mem[r_rd_ptr].kind;
    assign o_out.value = r_mem[r_rd_ptr].value;
    assign o_out.last  = r_mem[r_rd_ptr].last;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(n_in);
        n_rd_ptr = pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(n_in) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0 || i_push.v1) begin
            r_mem[r_wr_ptr] <= first;
        end
        if (i_push.v0 && i_push.v1) begin
            r_mem[wr_ptr_1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[dv/kpm_report_checker.sv]
// Checker for the report parser: predicts result events from accepted bytes and compares them.
module kpm_report_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kpm_in_if         i_bytes,
    kpm_out_if        i_events,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Events predicted but not yet seen at the output, oldest first.
    kpm_pkg::t_result pending_events[$];

    // Own copy of the parser walk.
    kpm_pkg::t_phase walk_phase;
    logic [3:0]  gathered;
    logic [63:0] field_acc;
    logic [31:0] infos_left;
    logic [31:0] records_left;
    logic [31:0] labels_left;
    logic [15:0] chars_left;
    logic        whole;

    int errors  = 0;
    int checked = 0;

    function automatic logic [3:0] bytes_in_field(input kpm_pkg::t_phase p);
        logic [3:0] n;
        case (p)
            kpm_pkg::PH_PERIOD, kpm_pkg::PH_INFO_CNT,
            kpm_pkg::PH_REC_CNT, kpm_pkg::PH_LBL_CNT:    n = 4'd4;
            kpm_pkg::PH_NAME_LEN, kpm_pkg::PH_QOS,
            kpm_pkg::PH_SLICE_LEN, kpm_pkg::PH_PLMN_LEN: n = 4'd2;
            kpm_pkg::PH_INT, kpm_pkg::PH_REAL:           n = 4'd8;
            default:                                     n = 4'd1;
        endcase
        return n;
    endfunction

    task automatic restart_walk();
        walk_phase   = kpm_pkg::PH_PERIOD;
        gathered     = '0;
        field_acc    = '0;
        infos_left   = '0;
        records_left = '0;
        labels_left  = '0;
        chars_left   = '0;
        whole        = 1'b0;
    endtask

    task automatic add_event(input logic [3:0] kind, input logic [63:0] value,
                             input logic last);
        kpm_pkg::t_result r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        pending_events.insert(pending_events.size(), r);
    endtask

    task automatic close_info();
        infos_left = infos_left - 32'd1;
        if (infos_left == 0) begin
            whole      = 1'b1;
            walk_phase = kpm_pkg::PH_DONE;
        end else begin
            walk_phase = kpm_pkg::PH_NAME_LEN;
        end
    endtask

    task automatic close_label();
        labels_left = labels_left - 32'd1;
        if (labels_left == 0) begin
            close_info();
        end else begin
            walk_phase = kpm_pkg::PH_QOS;
        end
    endtask

    task automatic take_string_byte(input logic [7:0] b);
        add_event(walk_phase, {56'd0, b}, 1'b0);
        chars_left = chars_left - 16'd1;
        if (chars_left == 0) begin
            case (walk_phase)
                kpm_pkg::PH_NAME_BYTE:  walk_phase = kpm_pkg::PH_REC_CNT;
                kpm_pkg::PH_SLICE_BYTE: walk_phase = kpm_pkg::PH_PLMN_LEN;
                default:                close_label();
            endcase
        end
    endtask

    task automatic finish_field(input logic [63:0] v);
        logic [63:0] shown;
        shown = v;
        // QoS shows the flag as a single bit above the value byte.
        if (walk_phase == kpm_pkg::PH_QOS) begin
            shown = {55'd0, (v[7:0] != 8'd0), v[15:8]};
        end
        add_event(walk_phase, shown, 1'b0);
        case (walk_phase)
            kpm_pkg::PH_PERIOD: walk_phase = kpm_pkg::PH_INFO_CNT;
            kpm_pkg::PH_INFO_CNT: begin
                infos_left = v[31:0];
                if (infos_left == 0) begin
                    whole      = 1'b1;
                    walk_phase = kpm_pkg::PH_DONE;
                end else begin
                    walk_phase = kpm_pkg::PH_NAME_LEN;
                end
            end
            kpm_pkg::PH_NAME_LEN: begin
                chars_left = v[15:0];
                walk_phase = (chars_left == 0) ? kpm_pkg::PH_REC_CNT
                                               : kpm_pkg::PH_NAME_BYTE;
            end
            kpm_pkg::PH_REC_CNT: begin
                records_left = v[31:0];
                walk_phase   = (records_left == 0) ? kpm_pkg::PH_LBL_CNT
                                                   : kpm_pkg::PH_FORM;
            end
            kpm_pkg::PH_FORM: walk_phase = kpm_pkg::PH_INT;
            kpm_pkg::PH_INT:  walk_phase = kpm_pkg::PH_REAL;
            kpm_pkg::PH_REAL: begin
                records_left = records_left - 32'd1;
                walk_phase   = (records_left == 0) ? kpm_pkg::PH_LBL_CNT
                                                   : kpm_pkg::PH_FORM;
            end
            kpm_pkg::PH_LBL_CNT: begin
                labels_left = v[31:0];
                if (labels_left == 0) begin
                    close_info();
                end else begin
                    walk_phase = kpm_pkg::PH_QOS;
                end
            end
            kpm_pkg::PH_QOS: walk_phase = kpm_pkg::PH_SLICE_LEN;
            kpm_pkg::PH_SLICE_LEN: begin
                chars_left = v[15:0];
                walk_phase = (chars_left == 0) ? kpm_pkg::PH_PLMN_LEN
                                               : kpm_pkg::PH_SLICE_BYTE;
            end
            kpm_pkg::PH_PLMN_LEN: begin
                chars_left = v[15:0];
                if (chars_left == 0) begin
                    close_label();
                end else begin
                    walk_phase = kpm_pkg::PH_PLMN_BYTE;
                end
            end
            default: begin
                whole      = 1'b1;
                walk_phase = kpm_pkg::PH_DONE;
            end
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eom);
        logic [63:0] v;
        if (!whole && walk_phase != kpm_pkg::PH_DONE) begin
            if (walk_phase == kpm_pkg::PH_NAME_BYTE ||
                walk_phase == kpm_pkg::PH_SLICE_BYTE ||
                walk_phase == kpm_pkg::PH_PLMN_BYTE) begin
                take_string_byte(b);
            end else begin
                field_acc = field_acc | ({56'd0, b} << (8 * gathered[2:0]));
                gathered  = {1'b0, gathered[2:0]} + 4'd1;
                if (gathered >= bytes_in_field(walk_phase)) begin
                    v         = field_acc;
                    field_acc = '0;
                    gathered  = '0;
                    finish_field(v);
                end
            end
        end
        if (eom) begin
            add_event(whole ? kpm_pkg::KIND_OK : kpm_pkg::KIND_TRUNC, 64'd0, 1'b1);
            restart_walk();
        end
    endtask

    task automatic check_event();
        kpm_pkg::t_result want;
        if (pending_events.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("%0t: unexpected event kind=%0d value=%h last=%0d", $realtime,
                         i_events.kind, i_events.value, i_events.last);
            end
        end else begin
            want = pending_events.pop_front();
            checked++;
            if (i_events.kind !== want.kind || i_events.value !== want.value ||
                i_events.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: event mismatch: expected kind=%0d value=%h last=%0d",
                             $realtime, want.kind, want.value, want.last);
                    $display("%0t: event mismatch: got kind=%0d value=%h last=%0d",
                             $realtime, i_events.kind, i_events.value, i_events.last);
                end
            end
        end
    endtask

    initial begin
        restart_walk();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_walk();
            pending_events.delete();
        end else begin
            if (i_events.valid && i_events.ready) begin
                check_event();
            end
            if (i_bytes.valid && i_bytes.ready) begin
                decode_byte(i_bytes.data_byte, i_bytes.end_of_message);
            end
        end
        o_pending <= pending_events.size();
        o_errors  <= errors;
        o_checked <= checked;
    end

endmodule

[dv/tb_kpm_report_tlv_parser_unit.sv]
// Testbench top: clock, reset, report byte stimulus, output stalls and the verdict.
module tb_kpm_report_tlv_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kpm_in_if  in_if ();
    kpm_out_if out_if ();

    int errors;
    int pending;
    int checked;

    int  cycle_count = 0;
    int  bytes_sent  = 0;
    int  msgs_sent   = 0;
    int  msgs_whole  = 0;
    bit  quiet       = 1'b0;
    int  tx_calm     = 0;

    logic [7:0] msg_q[$];

    kpm_report_tlv_parser_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    kpm_report_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bytes   (in_if),
        .i_events  (out_if),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d events outstanding.", pending);
            $display("FAIL");
            $finish;
        end
    end

    // Result side: stall bursts, calm stretches, and no stalls near the end.
    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (quiet || calm_left > 0) begin
                if (calm_left > 0) calm_left--;
                out_if.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 8) begin
                stall_left = $urandom_range(0, 14);
                out_if.ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 60);
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eom);
        if (!quiet && tx_calm == 0 && $urandom_range(0, 99) < 10) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end else if (tx_calm > 0) begin
            tx_calm--;
        end else if ($urandom_range(0, 99) < 3) begin
            tx_calm = $urandom_range(20, 60);
        end
        in_if.valid          <= 1'b1;
        in_if.data_byte      <= b;
        in_if.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send the first n bytes of the built message, flagging the last one.
    task automatic send_message(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(msg_q[i], i == n - 1);
        end
        msgs_sent++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic add_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) begin
            msg_q.insert(msg_q.size(), v[8*i +: 8]);
        end
    endtask

    task automatic add_string();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        add_le(64'(len), 2);
        for (int i = 0; i < len; i++) begin
            msg_q.insert(msg_q.size(), 8'($urandom_range(0, 255)));
        end
    endtask

    // Build a well-formed report with random content and small counts.
    task automatic build_report();
        int n_info;
        int n_rec;
        int n_lbl;
        msg_q.delete();
        add_le(64'($urandom), 4);
        n_info = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
        add_le(64'(n_info), 4);
        for (int i = 0; i < n_info; i++) begin
            add_string();
            n_rec = $urandom_range(0, 2);
            add_le(64'(n_rec), 4);
            for (int r = 0; r < n_rec; r++) begin
                // Form bytes span the full range, valid or not.
                add_le(64'($urandom_range(0, 255)), 1);
                add_le({$urandom, $urandom}, 8);
                add_le({$urandom, $urandom}, 8);
            end
            n_lbl = $urandom_range(0, 2);
            add_le(64'(n_lbl), 4);
            for (int l = 0; l < n_lbl; l++) begin
                add_le($urandom_range(0, 1) ? 64'($urandom_range(1, 255)) : 64'd0, 1);
                add_le(64'($urandom_range(0, 255)), 1);
                add_string();
                add_string();
            end
        end
    endtask

    initial begin
        int pick;
        bit drained_mid;
        drained_mid = 1'b0;
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.data_byte      <= 8'd0;
        in_if.end_of_message <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty report at the extremes with one trailing byte flagged final.
        msg_q.delete();
        add_le(64'hFFFF_FFFF, 4);
        add_le(64'd0, 4);
        add_le(64'h5A, 1);
        send_message(msg_q.size());
        msgs_whole++;
        // A lone final byte: truncated straight away.
        msg_q.delete();
        add_le(64'hFF, 1);
        send_message(1);
        // Final flag on the very byte that completes the structure.
        msg_q.delete();
        add_le(64'd0, 8);
        send_message(msg_q.size());
        msgs_whole++;
        wait_drained();

        while (bytes_sent < RANDOM_BYTES + 18) begin
            if (bytes_sent > (RANDOM_BYTES * 3) / 4) quiet = 1'b1;
            if (!drained_mid && bytes_sent > RANDOM_BYTES / 2) begin
                wait_drained();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                build_report();
                send_message(msg_q.size());
                msgs_whole++;
            end else if (pick < 70) begin
                build_report();
                add_le({$urandom, $urandom}, $urandom_range(1, 3));
                send_message(msg_q.size());
                msgs_whole++;
            end else if (pick < 85) begin
                build_report();
                send_message($urandom_range(1, msg_q.size() - 1));
            end else begin
                msg_q.delete();
                for (int i = $urandom_range(1, 12); i > 0; i--) begin
                    msg_q.insert(msg_q.size(), 8'($urandom_range(0, 255)));
                end
                send_message(msg_q.size());
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes in %0d messages (%0d complete, the rest cut short or noise).",
                 bytes_sent, msgs_sent, msgs_whole);
        $display("Checked %0d result events, %0d mismatches.", checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hdl/kpm_pkg.sv
hdl/kpm_if.sv
hdl/kpm_parse_core.sv
hdl/kpm_out_fifo.sv
hdl/kpm_report_tlv_parser_unit.sv
dv/kpm_report_checker.sv
dv/tb_kpm_report_tlv_parser_unit.sv
